// ===== hw/rtl/dbt_pkg.sv =====
// shared types, character codes and helpers for the byte tokenizer
package dbt_pkg;

  // default counter widths
  localparam int unsigned OffsetBitsDef = 24;
  localparam int unsigned LineBitsDef   = 16;
  localparam int unsigned ColumnBitsDef = 16;

  // number value width and saturation limit
  localparam int unsigned NumBits = 31;
  localparam logic [NumBits-1:0] NumMax = 31'h7FFF_FFFF;
  // largest accumulator that can take one more digit without overflow
  localparam logic [NumBits-1:0] NumThrLow  = 31'd214748364;
  localparam logic [NumBits-1:0] NumThrHigh = 31'd214748363;

  // word prefix holds the first five bytes of a word, newest lowest
  localparam int unsigned PrefixBits  = 40;
  localparam int unsigned PrefixBytes = 5;

  // keyword prefixes
  localparam logic [PrefixBits-1:0] KwAs    = 40'h00_0000_6173;
  localparam logic [PrefixBits-1:0] KwView  = 40'h00_7669_6577;
  localparam logic [PrefixBits-1:0] KwSum   = 40'h00_0073_756D;
  localparam logic [PrefixBits-1:0] KwAvg   = 40'h00_0061_7667;
  localparam logic [PrefixBits-1:0] KwMin   = 40'h00_006D_696E;
  localparam logic [PrefixBits-1:0] KwMax   = 40'h00_006D_6178;
  localparam logic [PrefixBits-1:0] KwCount = 40'h63_6F75_6E74;

  // character codes
  localparam logic [7:0] ChEnd    = 8'h00;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChZero   = 8'h30;

  // scan mode
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_HEADER = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_STRING = 3'd3,
    MODE_WORD   = 3'd4
  } dbt_mode_e;

  // token kinds
  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_HEADER  = 4'd1,
    KIND_LBRACE  = 4'd2,
    KIND_RBRACE  = 4'd3,
    KIND_COLON   = 4'd4,
    KIND_NUMBER  = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_AS      = 4'd7,
    KIND_VIEW    = 4'd8,
    KIND_SUM     = 4'd9,
    KIND_AVG     = 4'd10,
    KIND_MIN     = 4'd11,
    KIND_MAX     = 4'd12,
    KIND_COUNT   = 4'd13,
    KIND_IDENT   = 4'd14,
    KIND_UNKNOWN = 4'd15
  } dbt_kind_e;

  // which of the two result slots a step fills
  typedef struct packed {
    logic e0_vld;
    logic e1_vld;
  } dbt_push_t;

  // character classes
  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUscore);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

endpackage

// ===== hw/rtl/dbt_scanner.sv =====
// scan state and token decode for one source byte per step
module dbt_scanner import dbt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef,
  parameter int unsigned LINE_BITS   = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef,
  parameter int unsigned TDATA_W     = 120
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           char_i,
  output dbt_push_t            push_o,
  output logic [TDATA_W:0]     ent0_o,   // {last, tdata}
  output logic [TDATA_W:0]     ent1_o    // {last, tdata}
);

  localparam int unsigned RawW = 4 + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS + NumBits;
  localparam int unsigned MulW = NumBits + 4;

  // scan state
  dbt_mode_e                mode_q, mode_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d;
  logic [LINE_BITS-1:0]     line_q, line_d;
  logic [COLUMN_BITS-1:0]   col_q, col_d;
  logic [OFFSET_BITS-1:0]   st_off_q, st_off_d;
  logic [LINE_BITS-1:0]     st_line_q, st_line_d;
  logic [COLUMN_BITS-1:0]   st_col_q, st_col_d;
  logic [NumBits-1:0]       acc_q, acc_d;
  logic [PrefixBits-1:0]    prefix_q, prefix_d;

  // helper values
  logic [OFFSET_BITS-1:0]   off_next;
  logic [LINE_BITS-1:0]     line_mv;
  logic [COLUMN_BITS-1:0]   col_mv;
  logic [OFFSET_BITS-1:0]   len;
  logic [3:0]               digit;
  logic [NumBits-1:0]       acc_thr;
  logic [MulW-1:0]          acc_mul;
  logic [NumBits-1:0]       acc_sat;
  dbt_kind_e                word_kd;

  // ending token and rescan token
  logic                     a_vld, b_vld;
  dbt_kind_e                a_kind, b_kind;
  logic [OFFSET_BITS-1:0]   a_len;
  logic [NumBits-1:0]       a_val;
  logic [TDATA_W-1:0]       a_data, b_data;
  logic                     rescan, do_move, do_clear;

  // counter advance with saturation
  assign off_next = (off_q == '1) ? off_q : off_q + OFFSET_BITS'(1);
  assign line_mv  = (char_i != ChLf) ? line_q :
                    ((line_q == '1) ? line_q : line_q + LINE_BITS'(1));
  assign col_mv   = (char_i == ChLf) ? COLUMN_BITS'(1) :
                    ((col_q == '1) ? col_q : col_q + COLUMN_BITS'(1));
  assign len      = off_q - st_off_q;

  // saturating decimal accumulate
  assign digit   = char_i[3:0];
  assign acc_thr = (digit > 4'd7) ? NumThrHigh : NumThrLow;
  assign acc_mul = (MulW'(acc_q) << 3) + (MulW'(acc_q) << 1) + MulW'(digit);
  assign acc_sat = (acc_q > acc_thr) ? NumMax : acc_mul[NumBits-1:0];

  // keyword match
  always_comb begin
    word_kd = KIND_IDENT;
    if (len == OFFSET_BITS'(2) && prefix_q == KwAs) begin
      word_kd = KIND_AS;
    end else if (len == OFFSET_BITS'(4) && prefix_q == KwView) begin
      word_kd = KIND_VIEW;
    end else if (len == OFFSET_BITS'(3) && prefix_q == KwSum) begin
      word_kd = KIND_SUM;
    end else if (len == OFFSET_BITS'(3) && prefix_q == KwAvg) begin
      word_kd = KIND_AVG;
    end else if (len == OFFSET_BITS'(3) && prefix_q == KwMin) begin
      word_kd = KIND_MIN;
    end else if (len == OFFSET_BITS'(3) && prefix_q == KwMax) begin
      word_kd = KIND_MAX;
    end else if (len == OFFSET_BITS'(5) && prefix_q == KwCount) begin
      word_kd = KIND_COUNT;
    end
  end

  // next state and tokens for this byte
  always_comb begin
    mode_d    = mode_q;
    off_d     = off_q;
    line_d    = line_q;
    col_d     = col_q;
    st_off_d  = st_off_q;
    st_line_d = st_line_q;
    st_col_d  = st_col_q;
    acc_d     = acc_q;
    prefix_d  = prefix_q;
    a_vld     = 1'b0;
    a_kind    = KIND_EOF;
    a_len     = len;
    a_val     = '0;
    b_vld     = 1'b0;
    b_kind    = KIND_EOF;
    rescan    = 1'b0;
    do_move   = 1'b0;
    do_clear  = 1'b0;

    // finish or extend the current token
    case (mode_q)
      MODE_HEADER: begin
        if (char_i == ChLf || char_i == ChEnd) begin
          a_vld  = 1'b1;
          a_kind = KIND_HEADER;
          rescan = 1'b1;
        end else begin
          do_move = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_i)) begin
          acc_d   = acc_sat;
          do_move = 1'b1;
        end else begin
          a_vld  = 1'b1;
          a_kind = KIND_NUMBER;
          a_val  = acc_q;
          acc_d  = '0;
          rescan = 1'b1;
        end
      end
      MODE_STRING: begin
        if (char_i == ChQuote || char_i == ChEnd) begin
          a_vld  = 1'b1;
          a_kind = KIND_STRING;
          mode_d = MODE_IDLE;
          if (char_i == ChQuote) begin
            do_move = 1'b1;
          end else begin
            rescan = 1'b1;
          end
        end else begin
          do_move = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_word(char_i)) begin
          if (len < OFFSET_BITS'(PrefixBytes)) begin
            prefix_d = {prefix_q[PrefixBits-9:0], char_i};
          end
          do_move = 1'b1;
        end else begin
          a_vld    = 1'b1;
          a_kind   = word_kd;
          a_len    = (word_kd == KIND_IDENT) ? len : '0;
          prefix_d = '0;
          rescan   = 1'b1;
        end
      end
      default: begin
        rescan = 1'b1;
      end
    endcase

    // scan the byte from the idle state
    if (rescan) begin
      mode_d = MODE_IDLE;
      if (char_i == ChEnd) begin
        b_vld    = 1'b1;
        b_kind   = KIND_EOF;
        do_clear = 1'b1;
      end else if (is_space(char_i)) begin
        do_move = 1'b1;
      end else if (char_i == ChHash) begin
        st_off_d  = off_next;
        st_line_d = line_q;
        st_col_d  = col_q;
        mode_d    = MODE_HEADER;
        do_move   = 1'b1;
      end else if (char_i == ChLbrace || char_i == ChRbrace || char_i == ChColon) begin
        b_vld   = 1'b1;
        b_kind  = (char_i == ChLbrace) ? KIND_LBRACE :
                  ((char_i == ChRbrace) ? KIND_RBRACE : KIND_COLON);
        do_move = 1'b1;
      end else if (is_digit(char_i)) begin
        st_off_d  = off_q;
        st_line_d = line_q;
        st_col_d  = col_q;
        acc_d     = NumBits'(char_i - ChZero);
        mode_d    = MODE_NUMBER;
        do_move   = 1'b1;
      end else if (char_i == ChQuote) begin
        st_off_d  = off_next;
        st_line_d = line_q;
        st_col_d  = col_q;
        mode_d    = MODE_STRING;
        do_move   = 1'b1;
      end else if (is_alpha(char_i) || char_i == ChUscore) begin
        st_off_d  = off_q;
        st_line_d = line_q;
        st_col_d  = col_q;
        prefix_d  = PrefixBits'(char_i);
        mode_d    = MODE_WORD;
        do_move   = 1'b1;
      end else begin
        b_vld   = 1'b1;
        b_kind  = KIND_UNKNOWN;
        do_move = 1'b1;
      end
    end

    // advance position
    if (do_move) begin
      off_d  = off_next;
      line_d = line_mv;
      col_d  = col_mv;
    end

    // end of text returns every counter to its start
    if (do_clear) begin
      mode_d    = MODE_IDLE;
      off_d     = '0;
      line_d    = LINE_BITS'(1);
      col_d     = COLUMN_BITS'(1);
      st_off_d  = '0;
      st_line_d = LINE_BITS'(1);
      st_col_d  = COLUMN_BITS'(1);
      acc_d     = '0;
      prefix_d  = '0;
    end
  end

  // pack both tokens, kind in the lowest bits
  always_comb begin
    a_data = '0;
    b_data = '0;
    a_data[RawW-1:0] = {a_val, a_len, st_off_q, st_col_q, st_line_q, a_kind};
    b_data[RawW-1:0] = {{NumBits{1'b0}}, {OFFSET_BITS{1'b0}}, off_q, col_q, line_q, b_kind};
  end

  // order the results, last flag on the final one
  always_comb begin
    push_o.e0_vld = step_i & (a_vld | b_vld);
    push_o.e1_vld = step_i & a_vld & b_vld;
    ent0_o = a_vld ? {~b_vld, a_data} : {1'b1, b_data};
    ent1_o = {1'b1, b_data};
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      off_q     <= '0;
      line_q    <= LINE_BITS'(1);
      col_q     <= COLUMN_BITS'(1);
      st_off_q  <= '0;
      st_line_q <= LINE_BITS'(1);
      st_col_q  <= COLUMN_BITS'(1);
      acc_q     <= '0;
      prefix_q  <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      st_off_q  <= st_off_d;
      st_line_q <= st_line_d;
      st_col_q  <= st_col_d;
      acc_q     <= acc_d;
      prefix_q  <= prefix_d;
    end
  end

endmodule

// ===== hw/rtl/dbt_out_queue.sv =====
// three-entry result queue that takes up to two items per cycle while it holds at most one
module dbt_out_queue import dbt_pkg::*; #(
  parameter int unsigned W = 121
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dbt_push_t     push_i,
  input  logic [W-1:0]  ent0_i,
  input  logic [W-1:0]  ent1_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [W-1:0]  data_o
);

  localparam int unsigned Depth = 3;

  logic [1:0]   count_q, count_d;
  logic [1:0]   base;
  logic         pop;
  logic [W-1:0] slot_q [Depth];
  logic [W-1:0] slot_d [Depth];

  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[0];
  assign pop     = valid_o & ready_i;
  // room for a two-result byte
  assign space_o = (count_q <= 2'd1);
  assign base    = count_q - {1'b0, pop};

  // shift out the head, then append new items
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push_i.e0_vld && base == 2'(i)) begin
        slot_d[i] = ent0_i;
      end else if (push_i.e1_vld && base + 2'd1 == 2'(i)) begin
        slot_d[i] = ent1_i;
      end
    end
    count_d = base + {1'b0, push_i.e0_vld} + {1'b0, push_i.e1_vld};
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  // fill count never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth))
    else $error("result queue count out of range");

  // items only arrive while there is room for two
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.e0_vld |-> count_q <= 2'd1)
    else $error("result queue written while full");

  // second slot is never filled alone
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.e1_vld |-> push_i.e0_vld)
    else $error("second result without first");

  // count holds when there is neither a push nor a pop
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop && !push_i.e0_vld |=> count_q == $past(count_q))
    else $error("result queue count changed without traffic");

endmodule

// ===== hw/rtl/dsl_byte_tokenizer.sv =====
// top level of the streaming byte tokenizer
// a byte's tokens are decoded combinationally and written into the result queue when the byte is taken
// throughput: one byte per cycle while each byte gives at most one token and the
//   output is taken; a byte that gives two tokens holds the input until the three-entry
//   result queue is down to one item, draining one item per cycle while the output is taken
// reset: asynchronous, clears the scan state to offset 0, line 1, column 1 and empties the queue
module dsl_byte_tokenizer import dbt_pkg::*; #(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef,
  parameter int unsigned LINE_BITS   = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // char_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // token_kind, start_line, start_column, text_offset, text_length, number_value, zero pad
  output logic [((4 + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS + NumBits + 7) / 8) * 8 - 1:0]
                            m_axis_tdata,
  output logic              m_axis_tlast    // last_of_step
);

  localparam int unsigned RawW    = 4 + LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS + NumBits;
  localparam int unsigned TdataW  = ((RawW + 7) / 8) * 8;

  logic              step;
  dbt_push_t         push;
  logic [TdataW:0]   ent0, ent1, head;

  assign step = s_axis_tvalid & s_axis_tready;

  // byte scan and token decode
  dbt_scanner #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .TDATA_W     (TdataW)
  ) u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (s_axis_tdata),
    .push_o (push),
    .ent0_o (ent0),
    .ent1_o (ent1)
  );

  // result queue towards the output
  dbt_out_queue #(
    .W (TdataW + 1)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent0_i  (ent0),
    .ent1_i  (ent1),
    .space_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = head[TdataW-1:0];
  assign m_axis_tlast = head[TdataW];

endmodule

// ===== test/tb_dsl_byte_tokenizer.sv =====
// self-checking testbench for the streaming byte tokenizer
module tb_dsl_byte_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import dbt_pkg::*;

  localparam int unsigned OffB    = OffsetBitsDef;
  localparam int unsigned LineB   = LineBitsDef;
  localparam int unsigned ColB    = ColumnBitsDef;
  localparam int unsigned TdataW  = ((4 + LineB + ColB + 2 * OffB + NumBits + 7) / 8) * 8;
  localparam int unsigned LineLsb = 4;
  localparam int unsigned ColLsb  = LineLsb + LineB;
  localparam int unsigned OffLsb  = ColLsb + ColB;
  localparam int unsigned LenLsb  = OffLsb + OffB;
  localparam int unsigned ValLsb  = LenLsb + OffB;

  localparam int CycleLimit   = 200_000;
  localparam int LongHold     = 300;
  localparam int RandomItems  = 1400;
  localparam int DrainCycles  = 8;
  localparam int ReportLimit  = 40;
  localparam int TailLines    = 40;
  localparam int TailBlanks   = 70;

  // characters not in the package
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLowA  = "a";
  localparam logic [7:0] ChUpA   = "A";

  // keyword spellings, newest byte lowest
  localparam logic [PrefixBits-1:0] WordAs    = PrefixBits'("as");
  localparam logic [PrefixBits-1:0] WordView  = PrefixBits'("view");
  localparam logic [PrefixBits-1:0] WordSum   = PrefixBits'("sum");
  localparam logic [PrefixBits-1:0] WordAvg   = PrefixBits'("avg");
  localparam logic [PrefixBits-1:0] WordMin   = PrefixBits'("min");
  localparam logic [PrefixBits-1:0] WordMax   = PrefixBits'("max");
  localparam logic [PrefixBits-1:0] WordCount = PrefixBits'("count");

  typedef struct packed {
    dbt_kind_e            kind;
    logic [LineB-1:0]     line;
    logic [ColB-1:0]      column;
    logic [OffB-1:0]      offset;
    logic [OffB-1:0]      length;
    logic [NumBits-1:0]   value;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [7:0]       ch;
    logic             typed;
    dbt_kind_e        kind;
    logic [LineB-1:0] line;
    logic [ColB-1:0]  column;
    logic [OffB-1:0]  offset;
  } stim_row_t;

  // directed bytes; typed rows carry the single token they must give
  localparam stim_row_t DirectedRows [26] = '{
    // punctuation and unknown bytes straight after reset
    '{ChLbrace, 1'b1, KIND_LBRACE,  16'd1, 16'd1, 24'd0},
    '{ChRbrace, 1'b1, KIND_RBRACE,  16'd1, 16'd2, 24'd1},
    '{ChColon,  1'b1, KIND_COLON,   16'd1, 16'd3, 24'd2},
    '{8'hFF,    1'b1, KIND_UNKNOWN, 16'd1, 16'd4, 24'd3},
    '{8'h01,    1'b1, KIND_UNKNOWN, 16'd1, 16'd5, 24'd4},
    // header comment on the second line
    '{ChLf,     1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{ChHash,   1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"x",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{ChLf,     1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    // ten nines overflow the value
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"9",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    // quote closes the number and opens a string, cut short by the end byte
    '{ChQuote,  1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"a",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{ChEnd,    1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    // fresh text after the end: keyword then end
    '{"a",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{"s",      1'b0, KIND_EOF,     16'd0, 16'd0, 24'd0},
    '{ChSpace,  1'b1, KIND_AS,      16'd1, 16'd1, 24'd0},
    '{ChEnd,    1'b1, KIND_EOF,     16'd1, 16'd4, 24'd3}
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  token_t     pending_tokens [$];
  token_t     byte_tokens [2];
  int         byte_token_count;
  logic [7:0] text_bytes [$];
  string      keyword_list [7] = '{"as", "view", "sum", "avg", "min", "max", "count"};

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  counted_items  = 0;
  int  stall_left     = 0;
  bit  idle_on        = 1'b1;
  bit  hold_ask       = 1'b0;

  // scanner state of the predictor
  dbt_mode_e          scan_state;
  logic [OffB-1:0]    at_offset;
  logic [LineB-1:0]   at_line;
  logic [ColB-1:0]    at_column;
  logic [OffB-1:0]    lex_offset;
  logic [LineB-1:0]   lex_line;
  logic [ColB-1:0]    lex_column;
  logic [NumBits-1:0] value_acc;
  logic [PrefixBits-1:0] word_head;

  dsl_byte_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5ns clk_i = ~clk_i;

  // character classes
  function automatic bit digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void clear_scan();
    scan_state = MODE_IDLE;
    at_offset  = '0;
    at_line    = LineB'(1);
    at_column  = ColB'(1);
    lex_offset = '0;
    lex_line   = LineB'(1);
    lex_column = ColB'(1);
    value_acc  = '0;
    word_head  = '0;
  endfunction

  // move past one byte, counters saturating
  function automatic void step_forward(input logic [7:0] c);
    if (at_offset != '1) at_offset = at_offset + 1'b1;
    if (c == ChLf) begin
      if (at_line != '1) at_line = at_line + 1'b1;
      at_column = ColB'(1);
    end else if (at_column != '1) begin
      at_column = at_column + 1'b1;
    end
  endfunction

  function automatic void mark_lexeme(input logic [OffB-1:0] text_at);
    lex_offset = text_at;
    lex_line   = at_line;
    lex_column = at_column;
  endfunction

  function automatic void add_token(input dbt_kind_e k, input logic [LineB-1:0] l,
                                    input logic [ColB-1:0] col, input logic [OffB-1:0] o,
                                    input logic [OffB-1:0] n, input logic [NumBits-1:0] v);
    byte_tokens[byte_token_count] = '{kind: k, line: l, column: col, offset: o,
                                      length: n, value: v, last: 1'b0};
    byte_token_count++;
  endfunction

  function automatic logic [NumBits-1:0] grow_value(input logic [NumBits-1:0] acc,
                                                    input logic [7:0] c);
    int unsigned digit_val;
    int unsigned headroom;
    digit_val = 32'(c - ChZero);
    headroom  = (32'(NumMax) - digit_val) / 10;
    if (32'(acc) > headroom) return NumMax;
    return NumBits'(32'(acc) * 10 + digit_val);
  endfunction

  function automatic dbt_kind_e word_kind(input logic [OffB-1:0] span,
                                          input logic [PrefixBits-1:0] head);
    if (span == 2 && head == WordAs)    return KIND_AS;
    if (span == 4 && head == WordView)  return KIND_VIEW;
    if (span == 3 && head == WordSum)   return KIND_SUM;
    if (span == 3 && head == WordAvg)   return KIND_AVG;
    if (span == 3 && head == WordMin)   return KIND_MIN;
    if (span == 3 && head == WordMax)   return KIND_MAX;
    if (span == 5 && head == WordCount) return KIND_COUNT;
    return KIND_IDENT;
  endfunction

  // a byte seen between tokens
  function automatic void idle_scan(input logic [7:0] c);
    logic [OffB-1:0] text_at;
    text_at = (at_offset != '1) ? at_offset + 1'b1 : at_offset;
    if (c == ChEnd) begin
      add_token(KIND_EOF, at_line, at_column, at_offset, '0, '0);
      clear_scan();
    end else if (blank_char(c)) begin
      step_forward(c);
    end else if (c == ChHash) begin
      mark_lexeme(text_at);
      scan_state = MODE_HEADER;
      step_forward(c);
    end else if (c == ChLbrace || c == ChRbrace || c == ChColon) begin
      add_token(c == ChLbrace ? KIND_LBRACE : (c == ChRbrace ? KIND_RBRACE : KIND_COLON),
                at_line, at_column, at_offset, '0, '0);
      step_forward(c);
    end else if (digit_char(c)) begin
      mark_lexeme(at_offset);
      value_acc  = NumBits'(c - ChZero);
      scan_state = MODE_NUMBER;
      step_forward(c);
    end else if (c == ChQuote) begin
      mark_lexeme(text_at);
      scan_state = MODE_STRING;
      step_forward(c);
    end else if (letter_char(c) || c == ChUscore) begin
      mark_lexeme(at_offset);
      word_head  = PrefixBits'(c);
      scan_state = MODE_WORD;
      step_forward(c);
    end else begin
      add_token(KIND_UNKNOWN, at_line, at_column, at_offset, '0, '0);
      step_forward(c);
    end
  endfunction

  // tokens caused by one byte, left in byte_tokens
  function automatic void tokenize_byte(input logic [7:0] c);
    logic [OffB-1:0] span;
    dbt_kind_e       k;
    span = at_offset - lex_offset;
    byte_token_count = 0;
    case (scan_state)
      MODE_HEADER: begin
        if (c == ChLf || c == ChEnd) begin
          add_token(KIND_HEADER, lex_line, lex_column, lex_offset, span, '0);
          scan_state = MODE_IDLE;
          idle_scan(c);
        end else begin
          step_forward(c);
        end
      end
      MODE_NUMBER: begin
        if (digit_char(c)) begin
          value_acc = grow_value(value_acc, c);
          step_forward(c);
        end else begin
          add_token(KIND_NUMBER, lex_line, lex_column, lex_offset, span, value_acc);
          value_acc  = '0;
          scan_state = MODE_IDLE;
          idle_scan(c);
        end
      end
      MODE_STRING: begin
        if (c == ChQuote || c == ChEnd) begin
          add_token(KIND_STRING, lex_line, lex_column, lex_offset, span, '0);
          scan_state = MODE_IDLE;
          if (c == ChQuote) step_forward(c);
          else idle_scan(c);
        end else begin
          step_forward(c);
        end
      end
      MODE_WORD: begin
        if (letter_char(c) || digit_char(c) || c == ChUscore) begin
          if (span < 5) word_head = {word_head[PrefixBits-9:0], c};
          step_forward(c);
        end else begin
          k = word_kind(span, word_head);
          add_token(k, lex_line, lex_column, lex_offset, k == KIND_IDENT ? span : '0, '0);
          word_head  = '0;
          scan_state = MODE_IDLE;
          idle_scan(c);
        end
      end
      default: begin
        scan_state = MODE_IDLE;
        idle_scan(c);
      end
    endcase
    if (byte_token_count > 0) byte_tokens[byte_token_count-1].last = 1'b1;
  endfunction

  // idle lengths: mostly short, now and then long
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] random_word_char();
    case ($urandom_range(0, 3))
      0: return ChLowA + 8'($urandom_range(0, 25));
      1: return ChUpA + 8'($urandom_range(0, 25));
      2: return ChZero + 8'($urandom_range(0, 9));
      default: return ChUscore;
    endcase
  endfunction

  function automatic logic [7:0] random_blank();
    int pick;
    pick = $urandom_range(0, 5);
    return pick == 5 ? ChSpace : ChTab + 8'(pick);
  endfunction

  function automatic logic [7:0] random_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic void append_string(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  // mismatch report
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // offer one item, then book the tokens it must give
  task automatic send_byte(input logic [7:0] ch, input bit use_fixed, input token_t fixed);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    tokenize_byte(ch);
    if (use_fixed) begin
      pending_tokens.push_back(fixed);
    end else begin
      for (int i = 0; i < byte_token_count; i++) pending_tokens.push_back(byte_tokens[i]);
    end
  endtask

  task automatic send_text(input bit count_them);
    foreach (text_bytes[i]) begin
      send_byte(text_bytes[i], 1'b0, '0);
      if (count_them) counted_items++;
    end
  endtask

  // one lexeme of random content, sometimes slightly off a keyword
  task automatic add_piece();
    int    pick;
    int    n;
    string kw;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      kw = keyword_list[$urandom_range(0, 6)];
      case ($urandom_range(0, 9))
        0: kw = {kw, "s"};
        1: kw = kw.substr(0, kw.len() - 2);
        2: kw = kw.toupper();
        default: ;
      endcase
      append_string(kw);
    end else if (pick < 38) begin
      case ($urandom_range(0, 4))
        0: text_bytes.push_back(ChUscore);
        1: text_bytes.push_back(ChUpA + 8'($urandom_range(0, 25)));
        default: text_bytes.push_back(ChLowA + 8'($urandom_range(0, 25)));
      endcase
      repeat ($urandom_range(0, 9)) text_bytes.push_back(random_word_char());
    end else if (pick < 52) begin
      // now and then a number long enough that it may saturate
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
      repeat (n) text_bytes.push_back(ChZero + 8'($urandom_range(0, 9)));
    end else if (pick < 62) begin
      text_bytes.push_back(ChQuote);
      repeat ($urandom_range(0, 8)) text_bytes.push_back(random_byte_except(ChQuote, ChEnd));
      text_bytes.push_back(ChQuote);
    end else if (pick < 70) begin
      text_bytes.push_back(ChHash);
      repeat ($urandom_range(0, 10)) text_bytes.push_back(random_byte_except(ChLf, ChEnd));
      text_bytes.push_back(ChLf);
    end else if (pick < 86) begin
      case ($urandom_range(0, 2))
        0: text_bytes.push_back(ChLbrace);
        1: text_bytes.push_back(ChRbrace);
        default: text_bytes.push_back(ChColon);
      endcase
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 3)) text_bytes.push_back(random_blank());
    end else begin
      text_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // one text ending in the end byte, now and then with a string or header left open
  task automatic build_text();
    text_bytes.delete();
    repeat ($urandom_range(4, 30)) begin
      add_piece();
      if ($urandom_range(0, 9) < 6) text_bytes.push_back(random_blank());
    end
    case ($urandom_range(0, 7))
      0: begin
        text_bytes.push_back(ChQuote);
        repeat ($urandom_range(0, 4)) text_bytes.push_back(random_byte_except(ChQuote, ChEnd));
      end
      1: begin
        text_bytes.push_back(ChHash);
        repeat ($urandom_range(0, 4)) text_bytes.push_back(random_byte_except(ChLf, ChEnd));
      end
      default: ;
    endcase
    text_bytes.push_back(ChEnd);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask) begin
      hold_ask   = 1'b0;
      stall_left = LongHold;
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left = gap_length() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // token checker
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind   = dbt_kind_e'(m_axis_tdata[3:0]);
      got.line   = m_axis_tdata[LineLsb +: LineB];
      got.column = m_axis_tdata[ColLsb +: ColB];
      got.offset = m_axis_tdata[OffLsb +: OffB];
      got.length = m_axis_tdata[LenLsb +: OffB];
      got.value  = m_axis_tdata[ValLsb +: NumBits];
      got.last   = m_axis_tlast;
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("token kind %0d with none expected", got.kind));
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind != want.kind)
          flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.line != want.line)
          flag_mismatch($sformatf("line %0d, expected %0d", got.line, want.line));
        if (got.column != want.column)
          flag_mismatch($sformatf("column %0d, expected %0d", got.column, want.column));
        if (got.offset != want.offset)
          flag_mismatch($sformatf("offset %0d, expected %0d", got.offset, want.offset));
        if (got.length != want.length)
          flag_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
        if (got.value != want.value)
          flag_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.last != want.last)
          flag_mismatch($sformatf("tlast %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    token_t fixed;
    clear_scan();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (DirectedRows[i]) begin
      fixed = '{kind: DirectedRows[i].kind, line: DirectedRows[i].line,
                column: DirectedRows[i].column, offset: DirectedRows[i].offset,
                length: '0, value: '0, last: 1'b1};
      send_byte(DirectedRows[i].ch, DirectedRows[i].typed, fixed);
    end

    // random texts, the first one under a long output hold-off
    hold_ask = 1'b1;
    while (counted_items < RandomItems) begin
      idle_on = ($urandom_range(0, 4) != 0);
      build_text();
      send_text(1'b1);
    end

    // long runs of newlines and blanks around a last text
    idle_on = 1'b0;
    text_bytes.delete();
    repeat (TailLines) text_bytes.push_back(ChLf);
    append_string("ab 7 \"q\" #z");
    text_bytes.push_back(ChLf);
    repeat (TailBlanks) text_bytes.push_back(ChSpace);
    append_string("view 12:x\"s");
    text_bytes.push_back(ChEnd);
    send_text(1'b0);
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
